// ===== sv/world_to_screen_projection_assert.svh =====
// Assertion macros for the world-to-screen projection block.
`ifndef WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_ASSERT_SVH
`ifndef SYNTHESIS
// Condition a implies condition b in the same cycle.
`define WTSP_ASSERT_SAME(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");
// Condition a implies condition b in the next cycle.
`define WTSP_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define WTSP_ASSERT_SAME(label, clk, rst_n, a, b)
`define WTSP_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/wtsp_pkg.sv =====
// Shared constants for the world-to-screen projection block.
package wtsp_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SIZE_W        = 14;
	localparam int QUOT_BITS     = 40;
	localparam int ADDR_W        = 3;

	localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(800);
	localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(600);

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// request actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_POINT = 1'b1;
endpackage

// ===== sv/wtsp_if.sv =====
// Request and result channel interfaces of the projection block.
interface wtsp_point_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic        [3:0]  coef_index;
	logic signed [31:0] coef_value;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	modport source (output valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
		input ready);
	modport sink (input valid, action, coef_index, coef_value, pos_x, pos_y, pos_z,
		output ready);
endinterface

interface wtsp_screen_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] screen_x;
	logic signed [31:0] screen_y;
	logic               behind_camera;
	logic               saturated;
	modport source (output valid, screen_x, screen_y, behind_camera, saturated,
		input ready);
	modport sink (input valid, screen_x, screen_y, behind_camera, saturated,
		output ready);
endinterface

// ===== sv/world_to_screen_projection.sv =====
// Top level: pipelined world-to-screen projection with a loadable view matrix.
// Takes one request per cycle unless stalled, returning one result per point
// request, in order, through QUOT_BITS + 5 register stages (45 at defaults); a
// load request writes one entry of the 4x4 column-major matrix with no result.
// Two stages form clip x, y and w (nine parallel 32x32 multipliers, then the
// sums), one scales the numerators by the screen size and forms the divisor,
// one loads the divider head with the overflow test, QUOT_BITS stages of a
// restoring divider resolve one quotient bit each for x and y, and an output
// register applies sign, half-screen offset and clamp. Stalls on the result
// side back up stage by stage, so bubbles are filled before input ready drops.
// Screen sizes are APB registers at byte addresses 0 (width) and 4 (height).
`include "world_to_screen_projection_assert.svh"

module world_to_screen_projection
	import wtsp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	wtsp_point_if.sink        pnt,
	wtsp_screen_if.source     scr
);
	localparam int SHW = 64 - FRAC_BITS;
	localparam int CW  = SHW + 2;
	localparam int NW  = SIZE_W + CW + FRAC_BITS;
	localparam int DW  = CW + 1;
	localparam int QB  = QUOT_BITS;
	localparam int HW0 = SIZE_W + FRAC_BITS;
	localparam int SW  = ((HW0 > QB + 1) ? HW0 : QB + 1) + 2;
	localparam longint BEHIND_LIM = ((64'sd1 <<< (FRAC_BITS + 1)) + 10) / 20;

	localparam logic signed [SW-1:0] S32_MAX = SW'(64'sd2147483647);
	localparam logic signed [SW-1:0] S32_MIN = SW'(-64'sd2147483648);

	// configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? {{(32-SIZE_W){1'b0}}, height_q}
		: {{(32-SIZE_W){1'b0}}, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_WIDTH) width_q <= pwdata[SIZE_W-1:0];
			else height_q <= pwdata[SIZE_W-1:0];
		end
	end

	// stage enables, chained back from the output register
	logic en1, en2, en3, en_out;
	logic en_dv [QB+1];
	logic v1_s1, v2_s2, v3_s3, vo_s5;
	logic dv_v_s4 [QB+1];

	assign en_out = !vo_s5 || scr.ready;
	always_comb begin
		en_dv[QB] = !dv_v_s4[QB] || en_out;
		for (int k = QB - 1; k >= 0; k--) en_dv[k] = !dv_v_s4[k] || en_dv[k+1];
	end
	assign en3 = !v3_s3 || en_dv[0];
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign pnt.ready = en1;

	// view matrix, written by load requests
	logic signed [31:0] coef_q [16];
	logic               accept;

	assign accept = pnt.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) coef_q[i] <= '0;
		end else if (accept && pnt.action == ACT_LOAD) begin
			coef_q[pnt.coef_index] <= pnt.coef_value;
		end
	end

	// stage 1: nine coordinate-by-coefficient products
	logic signed [31:0] pos [3];
	logic signed [63:0] prod_s1 [3][3];
	logic signed [31:0] trans_s1 [3];

	assign pos[0] = pnt.pos_x;
	assign pos[1] = pnt.pos_y;
	assign pos[2] = pnt.pos_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v1_s1 <= 1'b0;
		else if (en1) v1_s1 <= pnt.valid && pnt.action == ACT_POINT;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= 64'(pos[k]) * 64'(coef_q[4'(4 * k + ((r == 2) ? 3 : r))]);
				end
				trans_s1[r] <= coef_q[4'(12 + ((r == 2) ? 3 : r))];
			end
		end
	end

	// stage 2: floor-scale the products and sum each clip row
	logic signed [CW-1:0] clip_s2 [3];
	logic signed [CW-1:0] clip_d [3];
	logic signed [63:0]   shp;

	always_comb begin
		shp = '0;
		for (int r = 0; r < 3; r++) begin
			clip_d[r] = CW'(trans_s1[r]);
			for (int k = 0; k < 3; k++) begin
				shp = prod_s1[r][k] >>> FRAC_BITS;
				clip_d[r] = clip_d[r] + CW'($signed(shp[SHW-1:0]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v2_s2 <= 1'b0;
		else if (en2) v2_s2 <= v1_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) for (int r = 0; r < 3; r++) clip_s2[r] <= clip_d[r];
	end

	// stage 3: scaled numerators, divisor, signs and flags
	logic [CW-1:0] mag_x, mag_y, mag_w;
	logic          wz;
	logic [NW-1:0] num_x_s3, num_y_s3;
	logic [DW-1:0] den_s3;
	logic          neg_x_s3, neg_y_s3, zq_x_s3, zq_y_s3, wz_s3, behind_s3;

	assign mag_x = clip_s2[0][CW-1] ? CW'(-clip_s2[0]) : CW'(clip_s2[0]);
	assign mag_y = clip_s2[1][CW-1] ? CW'(-clip_s2[1]) : CW'(clip_s2[1]);
	assign mag_w = clip_s2[2][CW-1] ? CW'(-clip_s2[2]) : CW'(clip_s2[2]);
	assign wz    = (clip_s2[2] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v3_s3 <= 1'b0;
		else if (en3) v3_s3 <= v2_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			num_x_s3  <= {(SIZE_W + CW)'(width_q) * (SIZE_W + CW)'(mag_x),
				{FRAC_BITS{1'b0}}};
			num_y_s3  <= {(SIZE_W + CW)'(height_q) * (SIZE_W + CW)'(mag_y),
				{FRAC_BITS{1'b0}}};
			den_s3    <= {mag_w, 1'b0};
			neg_x_s3  <= clip_s2[0][CW-1] ^ clip_s2[2][CW-1];
			neg_y_s3  <= clip_s2[1][CW-1] ^ clip_s2[2][CW-1];
			zq_x_s3   <= wz && (clip_s2[0] == '0);
			zq_y_s3   <= wz && (clip_s2[1] == '0);
			wz_s3     <= wz;
			behind_s3 <= clip_s2[2] < CW'(BEHIND_LIM);
		end
	end

	// stage 4 onward: restoring division, one quotient bit per stage
	logic [DW-1:0] rem_x_s4 [QB+1];
	logic [DW-1:0] rem_y_s4 [QB+1];
	logic [QB-1:0] lo_x_s4  [QB+1];
	logic [QB-1:0] lo_y_s4  [QB+1];
	logic [QB-1:0] q_x_s4   [QB+1];
	logic [QB-1:0] q_y_s4   [QB+1];
	logic [DW-1:0] den_s4   [QB+1];
	logic          big_x_s4 [QB+1];
	logic          big_y_s4 [QB+1];
	logic [5:0]    flg_s4   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) dv_v_s4[k] <= 1'b0;
		end else begin
			if (en_dv[0]) dv_v_s4[0] <= v3_s3;
			for (int k = 1; k <= QB; k++) if (en_dv[k]) dv_v_s4[k] <= dv_v_s4[k-1];
		end
	end

	// load the divider head: overflow test and leading remainder
	always_ff @(posedge clk) begin
		if (en_dv[0]) begin
			big_x_s4[0] <= DW'(num_x_s3[NW-1:QB]) >= den_s3;
			big_y_s4[0] <= DW'(num_y_s3[NW-1:QB]) >= den_s3;
			rem_x_s4[0] <= DW'(num_x_s3[NW-1:QB]);
			rem_y_s4[0] <= DW'(num_y_s3[NW-1:QB]);
			lo_x_s4[0]  <= num_x_s3[QB-1:0];
			lo_y_s4[0]  <= num_y_s3[QB-1:0];
			q_x_s4[0]   <= '0;
			q_y_s4[0]   <= '0;
			den_s4[0]   <= den_s3;
			flg_s4[0]   <= {neg_x_s3, neg_y_s3, zq_x_s3, zq_y_s3, wz_s3, behind_s3};
		end
	end

	genvar g;
	generate
		for (g = 0; g < QB; g++) begin : g_div
			logic [DW:0]   tx, ty;
			logic          gx, gy;

			assign tx = {rem_x_s4[g], lo_x_s4[g][QB-1]};
			assign ty = {rem_y_s4[g], lo_y_s4[g][QB-1]};
			assign gx = tx >= {1'b0, den_s4[g]};
			assign gy = ty >= {1'b0, den_s4[g]};

			always_ff @(posedge clk) begin
				if (en_dv[g+1]) begin
					rem_x_s4[g+1] <= gx ? DW'(tx - {1'b0, den_s4[g]}) : DW'(tx);
					rem_y_s4[g+1] <= gy ? DW'(ty - {1'b0, den_s4[g]}) : DW'(ty);
					lo_x_s4[g+1]  <= {lo_x_s4[g][QB-2:0], 1'b0};
					lo_y_s4[g+1]  <= {lo_y_s4[g][QB-2:0], 1'b0};
					q_x_s4[g+1]   <= {q_x_s4[g][QB-2:0], gx};
					q_y_s4[g+1]   <= {q_y_s4[g][QB-2:0], gy};
					den_s4[g+1]   <= den_s4[g];
					big_x_s4[g+1] <= big_x_s4[g];
					big_y_s4[g+1] <= big_y_s4[g];
					flg_s4[g+1]   <= flg_s4[g];
				end
			end
		end
	endgenerate

	// stage 5: sign, offset by half screen, clamp
	logic [QB:0]          qm_x, qm_y;
	logic signed [SW-1:0] half_x, half_y, sum_x, sum_y;
	logic                 zx, zy, neg_x, neg_y;
	logic signed [31:0]   sx_s5, sy_s5;
	logic                 behind_s5, sat_s5;
	logic                 cl_x, cl_y;

	assign neg_x  = flg_s4[QB][5];
	assign neg_y  = flg_s4[QB][4];
	assign zx     = flg_s4[QB][3];
	assign zy     = flg_s4[QB][2];
	assign qm_x   = zx ? '0 : (big_x_s4[QB] ? (QB+1)'(1) << QB : {1'b0, q_x_s4[QB]});
	assign qm_y   = zy ? '0 : (big_y_s4[QB] ? (QB+1)'(1) << QB : {1'b0, q_y_s4[QB]});
	assign half_x = SW'({width_q, {(FRAC_BITS-1){1'b0}}});
	assign half_y = SW'({height_q, {(FRAC_BITS-1){1'b0}}});
	assign sum_x  = neg_x ? half_x - SW'(qm_x) : half_x + SW'(qm_x);
	assign sum_y  = neg_y ? half_y + SW'(qm_y) : half_y - SW'(qm_y);
	assign cl_x   = (sum_x > S32_MAX) || (sum_x < S32_MIN);
	assign cl_y   = (sum_y > S32_MAX) || (sum_y < S32_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vo_s5 <= 1'b0;
		else if (en_out) vo_s5 <= dv_v_s4[QB];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			sx_s5 <= (sum_x > S32_MAX) ? 32'sh7fffffff
				: ((sum_x < S32_MIN) ? 32'sh80000000 : sum_x[31:0]);
			sy_s5 <= (sum_y > S32_MAX) ? 32'sh7fffffff
				: ((sum_y < S32_MIN) ? 32'sh80000000 : sum_y[31:0]);
			behind_s5 <= flg_s4[QB][0];
			sat_s5    <= flg_s4[QB][1] || cl_x || cl_y;
		end
	end

	assign scr.valid         = vo_s5;
	assign scr.screen_x      = sx_s5;
	assign scr.screen_y      = sy_s5;
	assign scr.behind_camera = behind_s5;
	assign scr.saturated     = sat_s5;

	// checks
	`WTSP_ASSERT_SAME(a_wz_behind, clk, arst_n, v3_s3 && wz_s3, behind_s3)
	`WTSP_ASSERT_SAME(a_stall_full, clk, arst_n, !pnt.ready, v1_s1)
	`WTSP_ASSERT_NEXT(a_drain, clk, arst_n, dv_v_s4[QB] && en_out, vo_s5)
	`WTSP_ASSERT_SAME(a_zero_num, clk, arst_n, v3_s3 && (zq_x_s3 || zq_y_s3), wz_s3)
endmodule
